// File: rtl/core/nsd_pkg.sv
// Shared types and constants for the netpbm stream decoder.
// Holds the request and response word layouts, character codes, format and error codes.
// No dependencies.
package nsd_pkg;

   // request word: one stream byte or an end-of-stream mark
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_word_type;

   // response word: one RGBA pixel or one error report
   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [15:0] column;
      logic [15:0] row_index;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [2:0]  pixel_format;
      logic        last_of_run;
      logic        last_of_image;
      logic [2:0]  error_code;
   } rsp_word_type;

   // character codes
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_1     = 8'h31;
   localparam logic [7:0] CHAR_7     = 8'h37;
   localparam logic [7:0] CHAR_8     = 8'h38;
   localparam logic [7:0] CHAR_9     = 8'h39;

   // pixel format codes
   localparam logic [2:0] FMT_P1 = 3'd0;
   localparam logic [2:0] FMT_P2 = 3'd1;
   localparam logic [2:0] FMT_P3 = 3'd2;
   localparam logic [2:0] FMT_P4 = 3'd3;
   localparam logic [2:0] FMT_P5 = 3'd4;
   localparam logic [2:0] FMT_P6 = 3'd5;
   localparam logic [2:0] FMT_P8 = 3'd6;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_MAGIC = 3'd1;
   localparam logic [2:0] ERR_BAD_TYPE  = 3'd2;
   localparam logic [2:0] ERR_BAD_SEP   = 3'd3;
   localparam logic [2:0] ERR_BAD_NUM   = 3'd4;
   localparam logic [2:0] ERR_FLOAT     = 3'd5;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_NL);
   endfunction

endpackage

// File: rtl/core/netpbm_stream_decoder.sv
// Netpbm stream decoder top level: header parser, pixel decoder and output skid stage.
// Depends on nsd_pkg for word types, character, format and error codes.
//
// The decoder takes one stream byte per cycle unless req_stall is high and returns RGBA
// pixels with column, row and last-of-image marks, or an error word that sends it back
// to waiting for the magic 'P'. A packed bitmap (P4) byte gives min(8, columns left in
// the row) pixels, one per cycle from a shift register while the skid is empty, and holds
// req_stall high after it is taken until its last pixel is out. Results land in an output
// register backed by a one-word skid register; when the consumer stalls and a second result
// is ready, the skid fills and req_stall stays high until the output register drains.
module netpbm_stream_decoder #(
   parameter int DIM_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nsd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nsd_pkg::rsp_word_type rsp_word
);

   // parse phases
   localparam logic [2:0] PH_MAGIC  = 3'd0;
   localparam logic [2:0] PH_TYPE   = 3'd1;
   localparam logic [2:0] PH_SEP    = 3'd2;
   localparam logic [2:0] PH_WIDTH  = 3'd3;
   localparam logic [2:0] PH_HEIGHT = 3'd4;
   localparam logic [2:0] PH_MAXVAL = 3'd5;
   localparam logic [2:0] PH_ASCII  = 3'd6;
   localparam logic [2:0] PH_BINARY = 3'd7;

   localparam logic [2:0] EXP_LAST = 3'd7;

   // parser state
   logic [2:0]          phase_ff, phase_in;
   logic [2:0]          format_ff, format_in;
   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [DIM_BITS-1:0] accum_ff, accum_in;
   logic                in_number_ff, in_number_in;
   logic                in_comment_ff, in_comment_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;
   logic [1:0]          comp_ff, comp_in;
   logic [7:0]          red_ff, red_in;
   logic [7:0]          green_ff, green_in;
   logic [7:0]          blue_ff, blue_in;

   // packed bitmap expansion
   logic                exp_busy_ff, exp_busy_in;
   logic [6:0]          exp_bits_ff, exp_bits_in;
   logic [2:0]          exp_idx_ff, exp_idx_in;

   // output register and skid
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   nsd_pkg::rsp_word_type rsp_ff;
   nsd_pkg::rsp_word_type skid_ff;

   // datapath
   logic                  acc_fire;
   logic                  exp_fire;
   logic                  out_take;
   logic                  rsp_load;
   logic                  skid_load;
   logic                  rsp_from_skid;
   logic [7:0]            c;
   logic [3:0]            digit;
   logic                  is_digit;
   logic [DIM_BITS+3:0]   acc_ext;
   logic [DIM_BITS+3:0]   acc_mul;
   logic [DIM_BITS-1:0]   acc_sat;
   logic [DIM_BITS+7:0]   acc_wide;
   logic [7:0]            samp;
   logic [DIM_BITS:0]     col_plus;
   logic [DIM_BITS:0]     row_plus;
   logic                  last_col;
   logic                  last_img;
   logic [DIM_BITS+15:0]  col_wide;
   logic [DIM_BITS+15:0]  row_wide;
   logic [DIM_BITS+15:0]  width_wide;
   logic [DIM_BITS+15:0]  height_wide;
   logic                  pix_emit;
   logic [7:0]            pix_red;
   logic [7:0]            pix_green;
   logic [7:0]            pix_blue;
   logic [7:0]            pix_alpha;
   logic                  pix_lor;
   logic                  err_emit;
   logic [2:0]            err_code;
   logic                  begin_px;
   logic [2:0]            begin_phase;
   logic                  go_idle;
   logic                  res_valid;
   nsd_pkg::rsp_word_type res;

   // handshake
   assign req_stall = skid_valid_ff || exp_busy_ff;
   assign acc_fire  = req_valid && !req_stall;
   assign exp_fire  = exp_busy_ff && !skid_valid_ff;
   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // number accumulation, saturating at the all-ones value
   assign c        = req_word.data_byte;
   assign is_digit = (c >= nsd_pkg::CHAR_0) && (c <= nsd_pkg::CHAR_9);
   assign digit    = 4'(c - nsd_pkg::CHAR_0);
   assign acc_ext  = {4'b0, accum_ff};
   assign acc_mul  = (acc_ext << 3) + (acc_ext << 1) + {{DIM_BITS{1'b0}}, digit};
   assign acc_sat  = (|acc_mul[DIM_BITS+3:DIM_BITS]) ? {DIM_BITS{1'b1}}
                                                     : acc_mul[DIM_BITS-1:0];
   assign acc_wide = {8'b0, accum_ff};
   assign samp     = (|acc_wide[DIM_BITS+7:8]) ? 8'hFF : acc_wide[7:0];

   // pixel position
   assign col_plus    = {1'b0, col_ff} + {{DIM_BITS{1'b0}}, 1'b1};
   assign row_plus    = {1'b0, row_ff} + {{DIM_BITS{1'b0}}, 1'b1};
   assign last_col    = (col_plus == {1'b0, width_ff});
   assign last_img    = last_col && (row_plus == {1'b0, height_ff});
   assign col_wide    = {16'b0, col_ff};
   assign row_wide    = {16'b0, row_ff};
   assign width_wide  = {16'b0, width_ff};
   assign height_wide = {16'b0, height_ff};

   // decode one byte or one expansion step
   always_comb begin
      phase_in      = phase_ff;
      format_in     = format_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      accum_in      = accum_ff;
      in_number_in  = in_number_ff;
      in_comment_in = in_comment_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      comp_in       = comp_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      exp_busy_in   = exp_busy_ff;
      exp_bits_in   = exp_bits_ff;
      exp_idx_in    = exp_idx_ff;
      pix_emit      = 1'b0;
      pix_red       = 8'h00;
      pix_green     = 8'h00;
      pix_blue      = 8'h00;
      pix_alpha     = nsd_pkg::ALPHA_OPAQUE;
      pix_lor       = 1'b1;
      err_emit      = 1'b0;
      err_code      = nsd_pkg::ERR_NONE;
      begin_px      = 1'b0;
      begin_phase   = PH_BINARY;
      go_idle       = 1'b0;

      if (exp_fire) begin
         // next bit of a packed bitmap byte
         pix_emit    = 1'b1;
         pix_red     = {8{exp_bits_ff[6]}};
         pix_green   = {8{exp_bits_ff[6]}};
         pix_blue    = {8{exp_bits_ff[6]}};
         pix_lor     = last_col || (exp_idx_ff == EXP_LAST);
         exp_bits_in = {exp_bits_ff[5:0], 1'b0};
         exp_idx_in  = exp_idx_ff + 3'd1;
         if (pix_lor) begin
            exp_busy_in = 1'b0;
         end
      end else if (acc_fire) begin
         if (req_word.end_of_data) begin
            // stream ended: report where it was cut
            if (phase_ff != PH_MAGIC) begin
               err_emit = 1'b1;
               if (phase_ff == PH_TYPE) begin
                  err_code = nsd_pkg::ERR_BAD_TYPE;
               end else if (phase_ff == PH_SEP) begin
                  err_code = nsd_pkg::ERR_BAD_SEP;
               end else begin
                  err_code = nsd_pkg::ERR_BAD_NUM;
               end
            end
         end else if (phase_ff == PH_MAGIC) begin
            if (c != nsd_pkg::CHAR_P) begin
               err_emit = 1'b1;
               err_code = nsd_pkg::ERR_BAD_MAGIC;
            end else begin
               phase_in = PH_TYPE;
            end
         end else if (phase_ff == PH_BINARY) begin
            // raw samples
            unique case (format_ff)
               nsd_pkg::FMT_P4: begin
                  pix_emit  = 1'b1;
                  pix_red   = {8{c[7]}};
                  pix_green = {8{c[7]}};
                  pix_blue  = {8{c[7]}};
                  pix_lor   = last_col;
                  if (!last_col) begin
                     exp_busy_in = 1'b1;
                     exp_bits_in = c[6:0];
                     exp_idx_in  = 3'd1;
                  end
               end
               nsd_pkg::FMT_P5: begin
                  pix_emit  = 1'b1;
                  pix_red   = c;
                  pix_green = c;
                  pix_blue  = c;
               end
               nsd_pkg::FMT_P6, nsd_pkg::FMT_P8: begin
                  if (comp_ff == 2'd0) begin
                     red_in  = c;
                     comp_in = 2'd1;
                  end else if (comp_ff == 2'd1) begin
                     green_in = c;
                     comp_in  = 2'd2;
                  end else if (comp_ff == 2'd2 && format_ff == nsd_pkg::FMT_P8) begin
                     blue_in = c;
                     comp_in = 2'd3;
                  end else if (format_ff == nsd_pkg::FMT_P8) begin
                     comp_in   = 2'd0;
                     pix_emit  = 1'b1;
                     pix_red   = red_ff;
                     pix_green = green_ff;
                     pix_blue  = blue_ff;
                     pix_alpha = c;
                  end else begin
                     comp_in   = 2'd0;
                     pix_emit  = 1'b1;
                     pix_red   = red_ff;
                     pix_green = green_ff;
                     pix_blue  = c;
                  end
               end
               default: begin
                  err_emit = 1'b1;
                  err_code = nsd_pkg::ERR_BAD_NUM;
               end
            endcase
         end else if (in_comment_ff) begin
            // drop comment text through its newline
            if (c == nsd_pkg::CHAR_NL) begin
               in_comment_in = 1'b0;
            end
         end else if (c == nsd_pkg::CHAR_HASH) begin
            in_comment_in = 1'b1;
         end else if (phase_ff == PH_TYPE) begin
            if (c == nsd_pkg::CHAR_F) begin
               err_emit = 1'b1;
               err_code = nsd_pkg::ERR_FLOAT;
            end else if (c < nsd_pkg::CHAR_1 || c > nsd_pkg::CHAR_8 || c == nsd_pkg::CHAR_7) begin
               err_emit = 1'b1;
               err_code = nsd_pkg::ERR_BAD_TYPE;
            end else begin
               format_in = (c == nsd_pkg::CHAR_8) ? nsd_pkg::FMT_P8 : 3'(c - nsd_pkg::CHAR_1);
               phase_in  = PH_SEP;
            end
         end else if (phase_ff == PH_SEP) begin
            if (!nsd_pkg::is_space(c)) begin
               err_emit = 1'b1;
               err_code = nsd_pkg::ERR_BAD_SEP;
            end else begin
               phase_in     = PH_WIDTH;
               accum_in     = '0;
               in_number_in = 1'b0;
            end
         end else if (is_digit) begin
            accum_in     = acc_sat;
            in_number_in = 1'b1;
         end else if (!nsd_pkg::is_space(c)) begin
            err_emit = 1'b1;
            err_code = nsd_pkg::ERR_BAD_NUM;
         end else if (in_number_ff) begin
            // a number just ended
            accum_in     = '0;
            in_number_in = 1'b0;
            unique case (phase_ff)
               PH_WIDTH: begin
                  width_in = accum_ff;
                  phase_in = PH_HEIGHT;
               end
               PH_HEIGHT: begin
                  height_in = accum_ff;
                  if (format_ff == nsd_pkg::FMT_P1) begin
                     begin_px    = 1'b1;
                     begin_phase = PH_ASCII;
                  end else if (format_ff == nsd_pkg::FMT_P4) begin
                     begin_px    = 1'b1;
                     begin_phase = PH_BINARY;
                  end else begin
                     phase_in = PH_MAXVAL;
                  end
               end
               PH_MAXVAL: begin
                  begin_px    = 1'b1;
                  begin_phase = (format_ff == nsd_pkg::FMT_P2 || format_ff == nsd_pkg::FMT_P3)
                                ? PH_ASCII : PH_BINARY;
               end
               default: begin
                  // ASCII sample
                  if (format_ff == nsd_pkg::FMT_P1) begin
                     pix_emit  = 1'b1;
                     pix_red   = {8{|accum_ff}};
                     pix_green = {8{|accum_ff}};
                     pix_blue  = {8{|accum_ff}};
                  end else if (format_ff == nsd_pkg::FMT_P2) begin
                     pix_emit  = 1'b1;
                     pix_red   = samp;
                     pix_green = samp;
                     pix_blue  = samp;
                  end else if (comp_ff == 2'd0) begin
                     red_in  = samp;
                     comp_in = 2'd1;
                  end else if (comp_ff == 2'd1) begin
                     green_in = samp;
                     comp_in  = 2'd2;
                  end else begin
                     comp_in   = 2'd0;
                     pix_emit  = 1'b1;
                     pix_red   = red_ff;
                     pix_green = green_ff;
                     pix_blue  = samp;
                  end
               end
            endcase
         end
      end

      // start the pixel section, or skip an empty image
      if (begin_px) begin
         col_in  = '0;
         row_in  = '0;
         comp_in = 2'd0;
         if (width_in == '0 || height_in == '0) begin
            go_idle = 1'b1;
         end else begin
            phase_in = begin_phase;
         end
      end

      // advance the pixel position
      if (pix_emit) begin
         if (last_col) begin
            col_in = '0;
            row_in = row_plus[DIM_BITS-1:0];
            if (row_plus >= {1'b0, height_ff}) begin
               go_idle = 1'b1;
            end
         end else begin
            col_in = col_plus[DIM_BITS-1:0];
         end
      end

      if (err_emit) begin
         go_idle = 1'b1;
      end

      // back to waiting for the magic byte
      if (go_idle) begin
         phase_in      = PH_MAGIC;
         accum_in      = '0;
         in_number_in  = 1'b0;
         in_comment_in = 1'b0;
         col_in        = '0;
         row_in        = '0;
         comp_in       = 2'd0;
      end

      // build the result word
      res_valid = pix_emit || err_emit;
      res       = '0;
      if (err_emit) begin
         res.error_code  = err_code;
         res.last_of_run = 1'b1;
      end else begin
         res.red           = pix_red;
         res.green         = pix_green;
         res.blue          = pix_blue;
         res.alpha         = pix_alpha;
         res.column        = col_wide[15:0];
         res.row_index     = row_wide[15:0];
         res.image_width   = width_wide[15:0];
         res.image_height  = height_wide[15:0];
         res.pixel_format  = format_ff;
         res.last_of_run   = pix_lor;
         res.last_of_image = last_img;
         res.error_code    = nsd_pkg::ERR_NONE;
      end
   end

   // steer a result into the output register or the skid
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_load      = 1'b0;
      rsp_from_skid = 1'b0;
      skid_load     = 1'b0;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_load      = 1'b1;
            rsp_from_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_load     = 1'b1;
            rsp_valid_in = 1'b1;
         end else begin
            skid_load     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC;
         format_ff     <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         accum_ff      <= '0;
         in_number_ff  <= 1'b0;
         in_comment_ff <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         comp_ff       <= 2'd0;
         red_ff        <= '0;
         green_ff      <= '0;
         blue_ff       <= '0;
         exp_busy_ff   <= 1'b0;
         exp_idx_ff    <= 3'd0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         format_ff     <= format_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         accum_ff      <= accum_in;
         in_number_ff  <= in_number_in;
         in_comment_ff <= in_comment_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         comp_ff       <= comp_in;
         red_ff        <= red_in;
         green_ff      <= green_in;
         blue_ff       <= blue_in;
         exp_busy_ff   <= exp_busy_in;
         exp_idx_ff    <= exp_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      exp_bits_ff <= exp_bits_in;
      if (rsp_load) begin
         rsp_ff <= rsp_from_skid ? skid_ff : res;
      end
      if (skid_load) begin
         skid_ff <= res;
      end
   end

   // the skid only fills behind a held output word
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held with empty output register");

   // no new result may be formed while the skid is full
   assert property (@(posedge clock) disable iff (reset) res_valid |-> !skid_valid_ff)
      else $error("result formed while skid is full");

   // bitmap expansion only runs inside a P4 pixel section
   assert property (@(posedge clock) disable iff (reset)
      exp_busy_ff |-> (phase_ff == PH_BINARY && format_ff == nsd_pkg::FMT_P4))
      else $error("bitmap expansion outside a P4 pixel section");

   // an error word always closes its run and sends the parser back to the magic byte
   assert property (@(posedge clock) disable iff (reset)
      err_emit |=> (phase_ff == PH_MAGIC && col_ff == '0 && row_ff == '0))
      else $error("parser not idle after error");

   // the last pixel of an image returns the parser to the magic byte
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && !err_emit && last_img) |=> (phase_ff == PH_MAGIC && !exp_busy_ff))
      else $error("parser not idle after last pixel");

endmodule

// File: dv/netpbm_stream_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench for netpbm_stream_decoder: a short directed table of stream bytes, then random
// netpbm images (well formed, truncated, corrupted, noise) checked against a local predictor.
// Depends on nsd_pkg and the decoder RTL.
module netpbm_stream_decoder_tb;

   localparam int NUM_DIRECTED = 25;
   localparam int RANDOM_ITEMS = 405;
   localparam int STUCK_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_PRINTS   = 40;
   localparam int MODE_SPAN    = 40;

   // how a stimulus row is checked: by the predictor, by a value typed into the table, or as giving no word
   typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_ERROR} check_kind_type;

   typedef struct packed {
      nsd_pkg::req_word_type word;
      check_kind_type        kind;
      logic [2:0]            code;
   } stim_row_type;

   // predictor parse phases
   localparam logic [2:0] WAIT_MAGIC = 3'd0;
   localparam logic [2:0] WAIT_TYPE  = 3'd1;
   localparam logic [2:0] WAIT_SEP   = 3'd2;
   localparam logic [2:0] GET_WIDTH  = 3'd3;
   localparam logic [2:0] GET_HEIGHT = 3'd4;
   localparam logic [2:0] GET_MAXVAL = 3'd5;
   localparam logic [2:0] ASCII_PIX  = 3'd6;
   localparam logic [2:0] BINARY_PIX = 3'd7;

   // directed stream: header errors, a commented P4 header, a short P4 row, a bad number
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      '{'{8'h00, 1'b1}, CHK_SILENT, nsd_pkg::ERR_NONE},      // end mark while idle
      '{'{8'h00, 1'b0}, CHK_ERROR, nsd_pkg::ERR_BAD_MAGIC},
      '{'{nsd_pkg::CHAR_P, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{nsd_pkg::CHAR_F, 1'b0}, CHK_ERROR, nsd_pkg::ERR_FLOAT},
      '{'{nsd_pkg::CHAR_P, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{nsd_pkg::CHAR_7, 1'b0}, CHK_ERROR, nsd_pkg::ERR_BAD_TYPE},
      '{'{nsd_pkg::CHAR_P, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{"2", 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{"x", 1'b0}, CHK_ERROR, nsd_pkg::ERR_BAD_SEP},
      '{'{nsd_pkg::CHAR_P, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{"4", 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{nsd_pkg::CHAR_SPACE, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{nsd_pkg::CHAR_HASH, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE}, // comment holding 0xFF
      '{'{8'hFF, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{nsd_pkg::CHAR_NL, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{nsd_pkg::CHAR_9, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},    // width 9
      '{'{nsd_pkg::CHAR_TAB, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{nsd_pkg::CHAR_1, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},    // height 1
      '{'{nsd_pkg::CHAR_CR, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{8'hFF, 1'b0}, CHK_MODEL, nsd_pkg::ERR_NONE},               // eight white pixels
      '{'{8'h00, 1'b0}, CHK_MODEL, nsd_pkg::ERR_NONE},               // one pixel left
      '{'{nsd_pkg::CHAR_P, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{"5", 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{nsd_pkg::CHAR_SPACE, 1'b0}, CHK_SILENT, nsd_pkg::ERR_NONE},
      '{'{"a", 1'b0}, CHK_ERROR, nsd_pkg::ERR_BAD_NUM}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   nsd_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   nsd_pkg::rsp_word_type rsp_word;

   // predictor state
   logic [2:0]   m_phase = WAIT_MAGIC;
   logic [2:0]   m_fmt = '0;
   logic [15:0]  m_width = '0, m_height = '0, m_accum = '0, m_col = '0, m_row = '0;
   logic         m_in_num = 1'b0, m_in_cmt = 1'b0;
   logic [1:0]   m_comp = '0;
   logic [7:0]   m_red = '0, m_green = '0, m_blue = '0;

   nsd_pkg::rsp_word_type step_q[$];
   nsd_pkg::rsp_word_type pixel_exp_q[$];
   stim_row_type          stream_q[$];
   stim_row_type          cur_item;
   int                    next_idx = 0;
   int                    taken_n = 0;
   int                    stuck_n = 0;
   int                    mismatch_n = 0;

   netpbm_stream_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit blank_char(input logic [7:0] c);
      return c == nsd_pkg::CHAR_SPACE || c == nsd_pkg::CHAR_TAB ||
             c == nsd_pkg::CHAR_CR || c == nsd_pkg::CHAR_NL;
   endfunction

   task automatic go_idle();
      m_phase  = WAIT_MAGIC;
      m_accum  = '0;
      m_in_num = 1'b0;
      m_in_cmt = 1'b0;
      m_col    = '0;
      m_row    = '0;
      m_comp   = '0;
   endtask

   task automatic flag_error(input logic [2:0] code);
      nsd_pkg::rsp_word_type e;
      e = '0;
      e.last_of_run = 1'b1;
      e.error_code  = code;
      step_q.push_back(e);
      go_idle();
   endtask

   task automatic start_pixels(input logic [2:0] p);
      m_col  = '0;
      m_row  = '0;
      m_comp = '0;
      if (m_width == 0 || m_height == 0) go_idle();
      else m_phase = p;
   endtask

   task automatic emit_pixel(input logic [7:0] r, g, b, a);
      nsd_pkg::rsp_word_type o;
      logic                  last_col;
      last_col        = (17'(m_col) + 17'd1 == 17'(m_width));
      o               = '0;
      o.red           = r;
      o.green         = g;
      o.blue          = b;
      o.alpha         = a;
      o.column        = m_col;
      o.row_index     = m_row;
      o.image_width   = m_width;
      o.image_height  = m_height;
      o.pixel_format  = m_fmt;
      o.last_of_image = last_col && (17'(m_row) + 17'd1 == 17'(m_height));
      step_q.push_back(o);
      // advance position, drop back to idle after the last row
      if (last_col) begin
         m_col = '0;
         if (17'(m_row) + 17'd1 >= 17'(m_height)) go_idle();
         else m_row = m_row + 16'd1;
      end else begin
         m_col = m_col + 16'd1;
      end
   endtask

   // collect color components; four-component pixels carry their own alpha
   task automatic add_component(input logic [7:0] s, input bit four);
      case (m_comp)
         2'd0: begin
            m_red  = s;
            m_comp = 2'd1;
         end
         2'd1: begin
            m_green = s;
            m_comp  = 2'd2;
         end
         2'd2: begin
            if (four) begin
               m_blue = s;
               m_comp = 2'd3;
            end else begin
               m_comp = 2'd0;
               emit_pixel(m_red, m_green, s, nsd_pkg::ALPHA_OPAQUE);
            end
         end
         default: begin
            m_comp = 2'd0;
            emit_pixel(m_red, m_green, m_blue, s);
         end
      endcase
   endtask

   task automatic number_end(input logic [15:0] v);
      logic [7:0] s;
      case (m_phase)
         GET_WIDTH: begin
            m_width = v;
            m_phase = GET_HEIGHT;
         end
         GET_HEIGHT: begin
            m_height = v;
            if (m_fmt == nsd_pkg::FMT_P1) start_pixels(ASCII_PIX);
            else if (m_fmt == nsd_pkg::FMT_P4) start_pixels(BINARY_PIX);
            else m_phase = GET_MAXVAL;
         end
         GET_MAXVAL: begin
            start_pixels((m_fmt == nsd_pkg::FMT_P2 || m_fmt == nsd_pkg::FMT_P3) ?
                         ASCII_PIX : BINARY_PIX);
         end
         default: begin
            s = (v > 16'd255) ? 8'd255 : v[7:0];
            if (m_fmt == nsd_pkg::FMT_P1) begin
               s = (v != 0) ? 8'd255 : 8'd0;
               emit_pixel(s, s, s, nsd_pkg::ALPHA_OPAQUE);
            end else if (m_fmt == nsd_pkg::FMT_P2) begin
               emit_pixel(s, s, s, nsd_pkg::ALPHA_OPAQUE);
            end else begin
               add_component(s, 1'b0);
            end
         end
      endcase
   endtask

   task automatic binary_sample(input logic [7:0] c);
      logic [15:0] left;
      logic [7:0]  v;
      int          cnt;
      case (m_fmt)
         nsd_pkg::FMT_P4: begin
            // a packed byte gives at most the columns left in the row, MSB first
            left = m_width - m_col;
            cnt  = (left < 16'd8) ? int'(left) : 8;
            for (int k = 0; k < cnt; k++) begin
               v = c[7 - k] ? 8'hFF : 8'h00;
               emit_pixel(v, v, v, nsd_pkg::ALPHA_OPAQUE);
            end
         end
         nsd_pkg::FMT_P5: emit_pixel(c, c, c, nsd_pkg::ALPHA_OPAQUE);
         nsd_pkg::FMT_P6: add_component(c, 1'b0);
         nsd_pkg::FMT_P8: add_component(c, 1'b1);
         default:         flag_error(nsd_pkg::ERR_BAD_NUM);
      endcase
   endtask

   // decode one stream word into step_q
   task automatic decode_byte(input nsd_pkg::req_word_type w);
      logic [7:0]            c;
      logic [31:0]           acc_next;
      logic [15:0]           v;
      nsd_pkg::rsp_word_type last;
      step_q.delete();
      c = w.data_byte;
      if (w.end_of_data) begin
         if (m_phase == WAIT_TYPE) flag_error(nsd_pkg::ERR_BAD_TYPE);
         else if (m_phase == WAIT_SEP) flag_error(nsd_pkg::ERR_BAD_SEP);
         else if (m_phase != WAIT_MAGIC) flag_error(nsd_pkg::ERR_BAD_NUM);
      end else if (m_phase == WAIT_MAGIC) begin
         if (c != nsd_pkg::CHAR_P) flag_error(nsd_pkg::ERR_BAD_MAGIC);
         else m_phase = WAIT_TYPE;
      end else if (m_phase == BINARY_PIX) begin
         binary_sample(c);
      end else if (m_in_cmt) begin
         if (c == nsd_pkg::CHAR_NL) m_in_cmt = 1'b0;
      end else if (c == nsd_pkg::CHAR_HASH) begin
         m_in_cmt = 1'b1;
      end else if (m_phase == WAIT_TYPE) begin
         if (c == nsd_pkg::CHAR_F) begin
            flag_error(nsd_pkg::ERR_FLOAT);
         end else if (c < nsd_pkg::CHAR_1 || c > nsd_pkg::CHAR_8 || c == nsd_pkg::CHAR_7) begin
            flag_error(nsd_pkg::ERR_BAD_TYPE);
         end else begin
            m_fmt   = (c == nsd_pkg::CHAR_8) ? nsd_pkg::FMT_P8 : 3'(c - nsd_pkg::CHAR_1);
            m_phase = WAIT_SEP;
         end
      end else if (m_phase == WAIT_SEP) begin
         if (!blank_char(c)) begin
            flag_error(nsd_pkg::ERR_BAD_SEP);
         end else begin
            m_phase  = GET_WIDTH;
            m_accum  = '0;
            m_in_num = 1'b0;
         end
      end else if (c >= nsd_pkg::CHAR_0 && c <= nsd_pkg::CHAR_9) begin
         // accumulate decimal digits, saturate at the dimension limit
         acc_next = 32'(m_accum) * 32'd10 + 32'(c - nsd_pkg::CHAR_0);
         m_accum  = (acc_next > 32'h0000_FFFF) ? 16'hFFFF : acc_next[15:0];
         m_in_num = 1'b1;
      end else if (!blank_char(c)) begin
         flag_error(nsd_pkg::ERR_BAD_NUM);
      end else if (m_in_num) begin
         v        = m_accum;
         m_accum  = '0;
         m_in_num = 1'b0;
         number_end(v);
      end
      // mark the final word of this byte
      if (step_q.size() > 0) begin
         last = step_q.pop_back();
         last.last_of_run = 1'b1;
         step_q.push_back(last);
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_n < MAX_PRINTS)
         $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatch_n++;
   endtask

   task automatic check_pixel(input nsd_pkg::rsp_word_type got);
      nsd_pkg::rsp_word_type want;
      if (pixel_exp_q.size() == 0) begin
         report_mismatch("word with nothing pending", 16'(got.error_code), 16'd0);
      end else begin
         want = pixel_exp_q.pop_front();
         if (got.red !== want.red)
            report_mismatch("red", 16'(got.red), 16'(want.red));
         if (got.green !== want.green)
            report_mismatch("green", 16'(got.green), 16'(want.green));
         if (got.blue !== want.blue)
            report_mismatch("blue", 16'(got.blue), 16'(want.blue));
         if (got.alpha !== want.alpha)
            report_mismatch("alpha", 16'(got.alpha), 16'(want.alpha));
         if (got.column !== want.column) report_mismatch("column", got.column, want.column);
         if (got.row_index !== want.row_index)
            report_mismatch("row_index", got.row_index, want.row_index);
         if (got.image_width !== want.image_width)
            report_mismatch("image_width", got.image_width, want.image_width);
         if (got.image_height !== want.image_height)
            report_mismatch("image_height", got.image_height, want.image_height);
         if (got.pixel_format !== want.pixel_format)
            report_mismatch("pixel_format", 16'(got.pixel_format), 16'(want.pixel_format));
         if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
         if (got.last_of_image !== want.last_of_image)
            report_mismatch("last_of_image", 16'(got.last_of_image), 16'(want.last_of_image));
         if (got.error_code !== want.error_code)
            report_mismatch("error_code", 16'(got.error_code), 16'(want.error_code));
      end
   endtask

   // queue what a taken byte should produce
   task automatic accept_byte(input stim_row_type item);
      nsd_pkg::rsp_word_type e;
      decode_byte(item.word);
      case (item.kind)
         CHK_MODEL: begin
            foreach (step_q[i]) pixel_exp_q.push_back(step_q[i]);
         end
         CHK_ERROR: begin
            e = '0;
            e.last_of_run = 1'b1;
            e.error_code  = item.code;
            pixel_exp_q.push_back(e);
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- stream builder

   task automatic put_word(input logic [7:0] b, input logic eod);
      stim_row_type r;
      r.word.data_byte   = b;
      r.word.end_of_data = eod;
      r.kind             = CHK_MODEL;
      r.code             = nsd_pkg::ERR_NONE;
      stream_q.push_back(r);
   endtask

   task automatic put_blank();
      case ($urandom_range(3))
         0:       put_word(nsd_pkg::CHAR_SPACE, 1'b0);
         1:       put_word(nsd_pkg::CHAR_TAB, 1'b0);
         2:       put_word(nsd_pkg::CHAR_CR, 1'b0);
         default: put_word(nsd_pkg::CHAR_NL, 1'b0);
      endcase
   endtask

   task automatic put_comment();
      logic [7:0] b;
      put_word(nsd_pkg::CHAR_HASH, 1'b0);
      repeat ($urandom_range(4)) begin
         b = 8'($urandom_range(255));
         put_word((b == nsd_pkg::CHAR_NL) ? nsd_pkg::CHAR_HASH : b, 1'b0);
      end
      put_word(nsd_pkg::CHAR_NL, 1'b0);
   endtask

   // separator run; a single blank where the next byte must be data or a new magic
   task automatic put_gap(input bit single);
      if ($urandom_range(5) == 0) put_comment();
      put_blank();
      if (!single && $urandom_range(2) == 0) put_blank();
   endtask

   task automatic put_number(input int v);
      int digs[$];
      int n;
      n = v;
      do begin
         digs.push_front(n % 10);
         n = n / 10;
      end while (n > 0);
      if ($urandom_range(7) == 0) put_word(nsd_pkg::CHAR_0, 1'b0);
      foreach (digs[i]) begin
         if (i > 0 && $urandom_range(11) == 0) put_comment();
         put_word(8'(nsd_pkg::CHAR_0 + digs[i]), 1'b0);
      end
   endtask

   // one image; an oversized one stops after its header
   task automatic add_image(input bit huge);
      logic [2:0] fmt;
      int         w, h, maxval, samples, nbytes, v;
      fmt = 3'($urandom_range(6));
      if (huge) fmt = $urandom_range(1) ? nsd_pkg::FMT_P4 : nsd_pkg::FMT_P5;
      w = ($urandom_range(15) == 0) ? 0 :
          (fmt == nsd_pkg::FMT_P4) ? $urandom_range(20, 1) : $urandom_range(3, 1);
      h = ($urandom_range(15) == 0) ? 0 : $urandom_range(3, 1);
      if (huge) begin
         w = $urandom_range(1) ? 65535 : 123456;
         h = $urandom_range(9, 1);
      end
      put_word(nsd_pkg::CHAR_P, 1'b0);
      if ($urandom_range(9) == 0) put_comment();
      put_word((fmt == nsd_pkg::FMT_P8) ? nsd_pkg::CHAR_8 : 8'(nsd_pkg::CHAR_1 + fmt), 1'b0);
      put_gap(1'b0);
      put_number(w);
      put_gap(1'b0);
      put_number(h);
      if (fmt != nsd_pkg::FMT_P1 && fmt != nsd_pkg::FMT_P4) begin
         put_gap(1'b0);
         maxval = ($urandom_range(3) == 0) ? $urandom_range(99999, 65536) :
                  $urandom_range(65535, 1);
         put_number(maxval);
      end
      put_gap(1'b1);
      if (!huge) begin
         if (fmt == nsd_pkg::FMT_P1 || fmt == nsd_pkg::FMT_P2 || fmt == nsd_pkg::FMT_P3) begin
            samples = w * h * ((fmt == nsd_pkg::FMT_P3) ? 3 : 1);
            for (int i = 0; i < samples; i++) begin
               if (fmt == nsd_pkg::FMT_P1)
                  v = ($urandom_range(7) == 0) ? $urandom_range(12, 2) : $urandom_range(1);
               else
                  v = ($urandom_range(3) == 0) ? $urandom_range(70000, 256) :
                      $urandom_range(255);
               if (i == 0 && $urandom_range(3) == 0) put_blank();
               put_number(v);
               put_gap(i == samples - 1);
            end
         end else begin
            nbytes = (fmt == nsd_pkg::FMT_P4) ? h * ((w + 7) / 8) :
                     w * h * ((fmt == nsd_pkg::FMT_P5) ? 1 :
                              (fmt == nsd_pkg::FMT_P6) ? 3 : 4);
            repeat (nbytes) put_word(8'($urandom_range(255)), 1'b0);
         end
      end
   endtask

   task automatic add_broken();
      int           start, cut, pos;
      stim_row_type r;
      start = stream_q.size();
      case ($urandom_range(3))
         0: begin
            // saturated width: a few pixel bytes, then the stream ends
            add_image(1'b1);
            repeat ($urandom_range(6, 1)) put_word(8'($urandom_range(255)), 1'b0);
            put_word(8'($urandom_range(255)), 1'b1);
         end
         1: begin
            // cut a good image short
            add_image(1'b0);
            cut = $urandom_range(stream_q.size() - 1, start + 1);
            while (stream_q.size() > cut) void'(stream_q.pop_back());
            put_word(8'($urandom_range(255)), 1'b1);
         end
         2: begin
            // corrupt one byte of a good image
            add_image(1'b0);
            pos = $urandom_range(stream_q.size() - 1, start);
            r = stream_q[pos];
            r.word.data_byte = 8'($urandom_range(255));
            stream_q[pos] = r;
         end
         default: begin
            // loose bytes, sometimes an end mark
            repeat ($urandom_range(3, 1)) put_word(8'($urandom_range(255)), 1'b0);
            if ($urandom_range(1)) put_word(8'($urandom_range(255)), 1'b1);
         end
      endcase
   endtask

   // ---------------------------------------------------------------- channels

   always @(posedge clock) begin : stream_io
      int mode;
      bit moved;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         // idle phases: none, sender, receiver, both
         mode    = (next_idx / MODE_SPAN) % 4;
         // a word counts as progress only while one is still expected
         moved   = (req_valid && !req_stall) ||
                   (rsp_valid && !rsp_stall && pixel_exp_q.size() > 0);
         stuck_n = moved ? 0 : stuck_n + 1;
         // check the word leaving the decoder
         if (rsp_valid && !rsp_stall) check_pixel(rsp_word);
         // book the byte taken at this edge
         if (req_valid && !req_stall) begin
            accept_byte(cur_item);
            taken_n++;
         end
         // offer the next byte, or hold a stalled one
         if (!req_valid || !req_stall) begin
            if (next_idx < stream_q.size() &&
                $urandom_range(99) >= ((mode == 1) ? 72 : (mode == 3) ? 16 : 0)) begin
               cur_item = stream_q[next_idx];
               next_idx++;
               req_valid <= 1'b1;
               req_word  <= cur_item.word;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= $urandom_range(99) < ((mode == 2) ? 72 : (mode == 3) ? 16 : 0);
      end
   end

   initial begin : tb_main
      for (int i = 0; i < NUM_DIRECTED; i++) stream_q.push_back(DIRECTED[i]);
      while (stream_q.size() < NUM_DIRECTED + RANDOM_ITEMS) begin
         if ($urandom_range(99) < 80) add_image(1'b0);
         else add_broken();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // wait for every byte to be taken and every word to come back
      while (!(taken_n == stream_q.size() && pixel_exp_q.size() == 0) &&
             stuck_n < STUCK_LIMIT)
         @(posedge clock);
      if (stuck_n >= STUCK_LIMIT) begin
         $display("Verification failed");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (pixel_exp_q.size() != 0)
            report_mismatch("words never arrived", 16'(pixel_exp_q.size()), 16'd0);
         if (mismatch_n == 0) $display("Verification passed");
         else $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/nsd_pkg.sv
rtl/core/netpbm_stream_decoder.sv
dv/netpbm_stream_decoder_tb.sv
